@@ rtl/vmc_pkg.sv @@
// Shared constants for the vector magnitude clamp datapath.
package vmc_pkg;

  // Bits consumed from the squared length by one square-root cell.
  localparam int unsigned SQRT_BITS_PER_CELL = 2;

  // Control word that runs beside each pipeline stage.
  typedef struct packed {
    logic vld;
  } vmc_ctl_t;

endpackage

@@ rtl/vmc_sqrt_cell.sv @@
// One restoring square-root cell: resolves one root bit per transaction step.
module vmc_sqrt_cell
  import vmc_pkg::*;
#(
  parameter int unsigned W  = 32,
  parameter int unsigned PW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  vmc_ctl_t        ctl_i,
  input  logic [2*W-1:0]  s_i,
  input  logic [W+1:0]    rem_i,
  input  logic [W-1:0]    root_i,
  input  logic [PW-1:0]   pay_i,
  output vmc_ctl_t        ctl_o,
  output logic [2*W-1:0]  s_o,
  output logic [W+1:0]    rem_o,
  output logic [W-1:0]    root_o,
  output logic [PW-1:0]   pay_o
);

  logic [W+3:0]   rs;
  logic [W+3:0]   trial;
  logic           ge;
  logic [W+3:0]   diff;
  vmc_ctl_t       ctl_r;
  logic [2*W-1:0] s_r;
  logic [W+1:0]   rem_r;
  logic [W-1:0]   root_r;
  logic [PW-1:0]  pay_r;

  always_comb begin
    rs    = {rem_i, s_i[2*W-1 -: SQRT_BITS_PER_CELL]};
    trial = {2'b00, root_i, 2'b01};
    ge    = (rs >= trial);
    diff  = rs - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
    if (en) begin
      s_r    <= s_i << SQRT_BITS_PER_CELL;
      rem_r  <= ge ? diff[W+1:0] : rs[W+1:0];
      root_r <= {root_i[W-2:0], ge};
      pay_r  <= pay_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign s_o    = s_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign pay_o  = pay_r;

endmodule

@@ rtl/vmc_div_cell.sv @@
// One restoring divide cell: one quotient bit for each of x and y per step.
module vmc_div_cell
  import vmc_pkg::*;
#(
  parameter int unsigned W  = 32,
  parameter int unsigned PW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  vmc_ctl_t       ctl_i,
  input  logic [W-1:0]   d_i,
  input  logic [W-1:0]   nx_i,
  input  logic [W-1:0]   rx_i,
  input  logic [W-1:0]   qx_i,
  input  logic [W-1:0]   ny_i,
  input  logic [W-1:0]   ry_i,
  input  logic [W-1:0]   qy_i,
  input  logic [PW-1:0]  pay_i,
  output vmc_ctl_t       ctl_o,
  output logic [W-1:0]   d_o,
  output logic [W-1:0]   nx_o,
  output logic [W-1:0]   rx_o,
  output logic [W-1:0]   qx_o,
  output logic [W-1:0]   ny_o,
  output logic [W-1:0]   ry_o,
  output logic [W-1:0]   qy_o,
  output logic [PW-1:0]  pay_o
);

  logic [W:0]    tx, ty, dx, dy;
  logic          gex, gey;
  vmc_ctl_t      ctl_r;
  logic [W-1:0]  d_r, nx_r, rx_r, qx_r, ny_r, ry_r, qy_r;
  logic [PW-1:0] pay_r;

  always_comb begin
    tx  = {rx_i, nx_i[W-1]};
    ty  = {ry_i, ny_i[W-1]};
    gex = (tx >= {1'b0, d_i});
    gey = (ty >= {1'b0, d_i});
    dx  = tx - {1'b0, d_i};
    dy  = ty - {1'b0, d_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
    if (en) begin
      d_r   <= d_i;
      nx_r  <= {nx_i[W-2:0], 1'b0};
      ny_r  <= {ny_i[W-2:0], 1'b0};
      rx_r  <= gex ? dx[W-1:0] : tx[W-1:0];
      ry_r  <= gey ? dy[W-1:0] : ty[W-1:0];
      qx_r  <= {qx_i[W-2:0], gex};
      qy_r  <= {qy_i[W-2:0], gey};
      pay_r <= pay_i;
    end
  end

  assign ctl_o = ctl_r;
  assign d_o   = d_r;
  assign nx_o  = nx_r;
  assign rx_o  = rx_r;
  assign qx_o  = qx_r;
  assign ny_o  = ny_r;
  assign ry_o  = ry_r;
  assign qy_o  = qy_r;
  assign pay_o = pay_r;

endmodule

@@ rtl/vector_magnitude_clamp.sv @@
// Top level of the 2D vector magnitude clamp pipeline.
// Limits the length of a signed fixed-point vector to max_magnitude. When
// x^2 + y^2 > max^2 each component becomes c * max / floor(sqrt(x^2 + y^2)),
// truncated toward zero, and out_tuser (clamped) is set; otherwise the vector
// passes unchanged. The raw integer math is independent of the fraction
// width, so any Q format of COMP_WIDTH bits works. One transaction is taken
// every cycle while in_tready is high. The path runs through register stages
// for abs, multiply, add and compare, a chain of COMP_WIDTH square-root cells
// and COMP_WIDTH divide cells, one bit per cell, and the output register. While
// out_tready is low the pipeline keeps moving until the output register and a
// one-entry skid register are both full; then the whole chain holds and
// in_tready drops until the skid entry drains.
module vector_magnitude_clamp
  import vmc_pkg::*;
#(
  parameter int unsigned COMP_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // vec_x, vec_y, max_magnitude, zero pad
  input  logic [((3*COMP_WIDTH-1+7)/8)*8-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // out_x, out_y, zero pad
  output logic [((2*COMP_WIDTH+7)/8)*8-1:0]     out_tdata,
  // clamped
  output logic                                  out_tuser
);

  localparam int unsigned W      = COMP_WIDTH;
  localparam int unsigned OUT_TW = ((2*W+7)/8)*8;
  localparam int unsigned PS     = 6*W + 1;
  localparam int unsigned PD     = 2*W + 3;

  logic en;

  // stage 0: magnitudes
  logic [W-1:0]   vx, vy, xa_nxt, ya_nxt;
  logic [W-2:0]   vm;
  vmc_ctl_t       c0_r;
  logic [W-1:0]   xa0_r, ya0_r, xr0_r, yr0_r;
  logic [W-2:0]   m0_r;
  logic           xn0_r, yn0_r;

  assign vx = in_tdata[W-1:0];
  assign vy = in_tdata[2*W-1:W];
  assign vm = in_tdata[3*W-2:2*W];
  assign xa_nxt = vx[W-1] ? (~vx + 1'b1) : vx;
  assign ya_nxt = vy[W-1] ? (~vy + 1'b1) : vy;

  // stage 1: products
  vmc_ctl_t       c1_r;
  logic [2*W-1:0] xx1_r, yy1_r;
  logic [2*W-3:0] mm1_r;
  logic [2*W-2:0] xm1_r, ym1_r;
  logic [W-1:0]   xr1_r, yr1_r;
  logic           xn1_r, yn1_r;

  // stage 2: squared length
  vmc_ctl_t       c2_r;
  logic [2*W-1:0] s2_r;
  logic [2*W-3:0] mm2_r;
  logic [2*W-2:0] xm2_r, ym2_r;
  logic [W-1:0]   xr2_r, yr2_r;
  logic           xn2_r, yn2_r;

  // stage 3: clamp decision
  vmc_ctl_t       c3_r;
  logic [2*W-1:0] s3_r;
  logic           gt3_r;
  logic [2*W-2:0] xm3_r, ym3_r;
  logic [W-1:0]   xr3_r, yr3_r;
  logic           xn3_r, yn3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r <= '0;
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else if (en) begin
      c0_r.vld <= in_tvalid;
      c1_r     <= c0_r;
      c2_r     <= c1_r;
      c3_r     <= c2_r;
    end
    if (en) begin
      xa0_r <= xa_nxt;
      ya0_r <= ya_nxt;
      xr0_r <= vx;
      yr0_r <= vy;
      m0_r  <= vm;
      xn0_r <= vx[W-1];
      yn0_r <= vy[W-1];

      xx1_r <= xa0_r * xa0_r;
      yy1_r <= ya0_r * ya0_r;
      mm1_r <= m0_r * m0_r;
      xm1_r <= (2*W-1)'(xa0_r * m0_r);
      ym1_r <= (2*W-1)'(ya0_r * m0_r);
      xr1_r <= xr0_r;
      yr1_r <= yr0_r;
      xn1_r <= xn0_r;
      yn1_r <= yn0_r;

      s2_r  <= xx1_r + yy1_r;
      mm2_r <= mm1_r;
      xm2_r <= xm1_r;
      ym2_r <= ym1_r;
      xr2_r <= xr1_r;
      yr2_r <= yr1_r;
      xn2_r <= xn1_r;
      yn2_r <= yn1_r;

      s3_r  <= s2_r;
      gt3_r <= (s2_r > {2'b00, mm2_r});
      xm3_r <= xm2_r;
      ym3_r <= ym2_r;
      xr3_r <= xr2_r;
      yr3_r <= yr2_r;
      xn3_r <= xn2_r;
      yn3_r <= yn2_r;
    end
  end

  // square-root cell chain
  vmc_ctl_t       sc   [0:W];
  logic [2*W-1:0] ss   [0:W];
  logic [W+1:0]   srem [0:W];
  logic [W-1:0]   sroot[0:W];
  logic [PS-1:0]  spay [0:W];

  assign sc[0]    = c3_r;
  assign ss[0]    = s3_r;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign spay[0]  = {gt3_r, xn3_r, yn3_r, xr3_r, yr3_r, xm3_r, ym3_r};

  for (genvar i = 0; i < W; i++) begin : g_sqrt
    vmc_sqrt_cell #(.W(W), .PW(PS)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (sc[i]),
      .s_i    (ss[i]),
      .rem_i  (srem[i]),
      .root_i (sroot[i]),
      .pay_i  (spay[i]),
      .ctl_o  (sc[i+1]),
      .s_o    (ss[i+1]),
      .rem_o  (srem[i+1]),
      .root_o (sroot[i+1]),
      .pay_o  (spay[i+1])
    );
  end

  // divide cell chain
  logic [2*W-2:0] xm_s, ym_s;
  logic [PD-1:0]  pd_s;

  assign {pd_s, xm_s, ym_s} = spay[W];

  vmc_ctl_t      dc [0:W];
  logic [W-1:0]  dd [0:W];
  logic [W-1:0]  dnx[0:W];
  logic [W-1:0]  drx[0:W];
  logic [W-1:0]  dqx[0:W];
  logic [W-1:0]  dny[0:W];
  logic [W-1:0]  dry[0:W];
  logic [W-1:0]  dqy[0:W];
  logic [PD-1:0] dpay[0:W];

  // a zero root only shows up for vectors that do not clamp
  assign dc[0]   = sc[W];
  assign dd[0]   = (sroot[W] == '0) ? W'(1) : sroot[W];
  assign dnx[0]  = xm_s[W-1:0];
  assign drx[0]  = {1'b0, xm_s[2*W-2:W]};
  assign dqx[0]  = '0;
  assign dny[0]  = ym_s[W-1:0];
  assign dry[0]  = {1'b0, ym_s[2*W-2:W]};
  assign dqy[0]  = '0;
  assign dpay[0] = pd_s;

  for (genvar i = 0; i < W; i++) begin : g_div
    vmc_div_cell #(.W(W), .PW(PD)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (dc[i]),
      .d_i   (dd[i]),
      .nx_i  (dnx[i]),
      .rx_i  (drx[i]),
      .qx_i  (dqx[i]),
      .ny_i  (dny[i]),
      .ry_i  (dry[i]),
      .qy_i  (dqy[i]),
      .pay_i (dpay[i]),
      .ctl_o (dc[i+1]),
      .d_o   (dd[i+1]),
      .nx_o  (dnx[i+1]),
      .rx_o  (drx[i+1]),
      .qx_o  (dqx[i+1]),
      .ny_o  (dny[i+1]),
      .ry_o  (dry[i+1]),
      .qy_o  (dqy[i+1]),
      .pay_o (dpay[i+1])
    );
  end

  // result assembly
  logic          gt_f, xn_f, yn_f;
  logic [W-1:0]  xr_f, yr_f, rx_f, ry_f;

  assign {gt_f, xn_f, yn_f, xr_f, yr_f} = dpay[W];
  assign rx_f = gt_f ? (xn_f ? (~dqx[W] + 1'b1) : dqx[W]) : xr_f;
  assign ry_f = gt_f ? (yn_f ? (~dqy[W] + 1'b1) : dqy[W]) : yr_f;

  // output register and skid
  logic          out_vld_r, skid_vld_r;
  logic [W-1:0]  ox_r, oy_r, kx_r, ky_r;
  logic          oc_r, kc_r;
  logic          take, arrive;

  assign en     = !skid_vld_r;
  assign take   = out_vld_r && out_tready;
  assign arrive = en && dc[W].vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (take) begin
        skid_vld_r <= 1'b0;
      end
    end else if (arrive) begin
      if (!out_vld_r || take) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (take) begin
      out_vld_r <= 1'b0;
    end

    if (skid_vld_r) begin
      if (take) begin
        ox_r <= kx_r;
        oy_r <= ky_r;
        oc_r <= kc_r;
      end
    end else if (arrive) begin
      if (!out_vld_r || take) begin
        ox_r <= rx_f;
        oy_r <= ry_f;
        oc_r <= gt_f;
      end else begin
        kx_r <= rx_f;
        ky_r <= ry_f;
        kc_r <= gt_f;
      end
    end
  end

  assign in_tready  = en;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TW'({oy_r, ox_r});
  assign out_tuser  = oc_r;

  // skid holds data only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid full with output register empty");

  // a stalled pipeline keeps its first stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(c0_r) && $stable(xr0_r))
    else $error("pipeline moved while stalled");

  // a vector that does not clamp leaves unchanged
  a_pass_unclamped: assert property (@(posedge clk) disable iff (!rst_n)
    arrive && !gt_f |-> rx_f == xr_f && ry_f == yr_f)
    else $error("unclamped vector altered");

endmodule

@@ verif/vector_magnitude_clamp_tb.sv @@
// Self-checking stream testbench for the vector magnitude clamp.
module vector_magnitude_clamp_tb;
  import vmc_pkg::*;

  localparam int unsigned W = 32;
  localparam int unsigned IN_BITS = ((3*W-1+7)/8)*8;
  localparam int unsigned OUT_BITS = ((2*W+7)/8)*8;
  localparam int unsigned LATENCY = 2*W + 5;
  localparam int unsigned N_RANDOM = 1830;
  localparam int unsigned STALL_LEN = 400;
  localparam int unsigned WATCHDOG = 5000;

  typedef struct packed {
    logic [W-2:0] max_mag;
    logic [W-1:0] vy;
    logic [W-1:0] vx;
  } vec_item_t;

  typedef struct packed {
    logic [W-1:0] ox;
    logic [W-1:0] oy;
    logic         clamped;
  } clamp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_BITS-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;
  logic out_tuser;

  vector_magnitude_clamp #(.COMP_WIDTH(W)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #1 clk = ~clk;

  vec_item_t     pending_vecs[$];
  clamp_result_t expected_clamps[$];
  int unsigned   n_errors = 0;
  int unsigned   n_accepted = 0;
  int unsigned   n_results = 0;
  int unsigned   n_clamped = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   cycle = 0;
  bit            stall_hold = 1'b0;

  // floor(sqrt(s)) for a 64-bit square sum plus carry (65 bits)
  function automatic logic [63:0] isqrt65(logic [64:0] s);
    logic [66:0] rem;
    logic [66:0] trial;
    logic [63:0] root;
    rem = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | ((s >> (2*i)) & 65'd3);
      trial = ({3'b0, root} << 2) | 67'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic clamp_result_t predict_clamp(vec_item_t v);
    clamp_result_t r;
    logic [W-1:0] xa, ya;
    logic [64:0] sq, mm;
    logic [63:0] len;
    logic [95:0] qx, qy;
    xa = v.vx[W-1] ? -v.vx : v.vx;
    ya = v.vy[W-1] ? -v.vy : v.vy;
    sq = 65'(64'(xa) * 64'(xa)) + 65'(64'(ya) * 64'(ya));
    mm = 65'(64'(v.max_mag) * 64'(v.max_mag));
    if (sq > mm) begin
      len = isqrt65(sq);
      if (len == 0) len = 1;
      qx = (96'(xa) * 96'(v.max_mag)) / 96'(len);
      qy = (96'(ya) * 96'(v.max_mag)) / 96'(len);
      r.ox = v.vx[W-1] ? -qx[W-1:0] : qx[W-1:0];
      r.oy = v.vy[W-1] ? -qy[W-1:0] : qy[W-1:0];
      r.clamped = 1'b1;
    end else begin
      r.ox = v.vx;
      r.oy = v.vy;
      r.clamped = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return W'($signed($urandom_range(0, 2000)) - 1000);
      3: return W'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [W-2:0] rand_mag();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return (W-1)'($urandom_range(0, 1000));
      3: return (W-1)'($urandom_range(0, 32'h0030_0000));
      default: return (W-1)'($urandom);
    endcase
  endfunction

  task automatic add_vec(logic [W-1:0] x, logic [W-1:0] y, logic [W-2:0] m);
    vec_item_t v;
    v.vx = x;
    v.vy = y;
    v.max_mag = m;
    pending_vecs.push_back(v);
  endtask

  // sender: ~10% idle, except for a clean stretch in the middle of the run
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_clamps.push_back(predict_clamp(vec_item_t'(in_tdata[3*W-2:0])));
        n_accepted <= n_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_vecs.size() > 0 &&
            ((n_accepted > 600 && n_accepted < 900) || $urandom_range(0, 99) >= 10)) begin
          in_tdata <= IN_BITS'(pending_vecs.pop_front());
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random backpressure, one long hold-off while the input keeps going
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        clamp_result_t got, exp_r;
        got.ox = out_tdata[W-1:0];
        got.oy = out_tdata[2*W-1:W];
        got.clamped = out_tuser;
        n_results <= n_results + 1;
        if (expected_clamps.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h clamped=%b",
                   $time, got.ox, got.oy, got.clamped);
          n_errors <= n_errors + 1;
        end else begin
          exp_r = expected_clamps.pop_front();
          if (exp_r.clamped) n_clamped <= n_clamped + 1;
          if (got !== exp_r) begin
            $display("%0t: mismatch expected x=%h y=%h clamped=%b, actual x=%h y=%h clamped=%b",
                     $time, exp_r.ox, exp_r.oy, exp_r.clamped, got.ox, got.oy, got.clamped);
            n_errors <= n_errors + 1;
          end
        end
      end
      out_tready <= stall_hold ? 1'b0 :
                    (n_accepted > 600 && n_accepted < 900) ? 1'b1 :
                    ($urandom_range(0, 99) >= 10);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned hold;
    add_vec('0, '0, '0);                           // zero vector, zero max
    add_vec('0, '0, 31'h7fff_ffff);
    add_vec(32'h0001_0000, '0, '0);                // zero max clamps to origin
    add_vec(32'h0003_0000, 32'h0004_0000, 31'h0005_0000); // length equals max
    add_vec(32'h0003_0000, 32'h0004_0001, 31'h0005_0000); // just over
    add_vec(32'hfffd_0000, 32'hfffc_0000, 31'h0002_8000);
    add_vec(32'h8000_0000, 32'h8000_0000, '0);     // most negative components
    add_vec(32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff);
    add_vec(32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
    add_vec(32'h7fff_ffff, 32'h8000_0000, 31'h0000_0001);
    add_vec(32'h0000_0001, 32'hffff_ffff, 31'h0000_0001);
    add_vec(32'hffff_ffff, '0, '0);
    add_vec('0, 32'h8000_0000, 31'h4000_0000);
    add_vec(32'h0010_0000, 32'h0010_0000, 31'h7fff_ffff);
    for (int i = 0; i < N_RANDOM; i++) add_vec(rand_comp(), rand_comp(), rand_mag());

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_accepted > 300);
    @(posedge clk);
    stall_hold <= 1'b1;
    for (hold = 0; hold < STALL_LEN; hold++) @(posedge clk);
    stall_hold <= 1'b0;
  end

  initial begin
    wait (rst_n);
    while (pending_vecs.size() > 0 || in_tvalid || expected_clamps.size() > 0) begin
      @(posedge clk);
      if (idle_cycles > WATCHDOG) begin
        $display("timeout: %0d results outstanding", expected_clamps.size());
        $display("status: fail");
        $finish;
      end
    end
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d vectors, %0d of them clamped, in %0d cycles",
             n_accepted, n_clamped, cycle);
    if (n_errors == 0 && expected_clamps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/vmc_pkg.sv
rtl/vmc_sqrt_cell.sv
rtl/vmc_div_cell.sv
rtl/vector_magnitude_clamp.sv
verif/vector_magnitude_clamp_tb.sv
